// ----- rtl/core/bft_pkg.sv -----
package bft_pkg;

    // Result codes carried on the result channel's tuser.
    typedef enum logic [1:0] {
        FLOW_FOUND = 2'd0,
        FLOW_NEW   = 2'd1,
        FLOW_FULL  = 2'd2,
        FLOW_SWEEP = 2'd3
    } flow_status_t;

    localparam int TUPLE_W = 96;
    localparam int TIME_W  = 32;
    localparam int TMO_W   = 16;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd300;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         capture;
        logic         ptr_clear;
        logic         rd_go;
        logic         scan_en;
        logic         sweep_en;
        logic         sweep_commit;
        logic         append_wr;
        logic         res_set;
        flow_status_t res_status;
        logic         out_load;
    } bft_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_sweep;
        logic hit;
        logic scan_done;
        logic table_full;
        logic out_free;
    } bft_stat_t;

endpackage

// ----- rtl/core/bidirectional_flow_table.sv -----
// Channel   | Dir | Handshake               | Payload
// ----------+-----+-------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid/tready    | tuser: cmd; tdata: addresses, ports, time
// m_axis    | out | m_axis_tvalid/tready    | tuser: status; tdata: slot, entry count
// cfg       | in  | cfg_we (no wait)        | cfg_wdata: timeout_seconds
//
// A lookup or a sweep reads the live entries through the single read port of the
// entry memory, one entry per cycle; a lookup that finds the table full adds a sweep.
// Reset (aresetn, synchronous, active low) empties the table and loads a timeout
// of 300; the entry memory itself is not cleared. A stalled result waits in the
// output register and the next item is taken once it has been loaded there.
module bidirectional_flow_table
    import bft_pkg::*;
#(
    parameter int FLOW_ENTRIES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] source_address, [63:32] dest_address, [79:64] source_port_num,
    // [95:80] dest_port_num, [127:96] now_time
    input  logic [127:0] s_axis_tdata,
    // [0] cmd
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [5:0] slot_index, [12:6] entry_count, [15:13] zero
    output logic [15:0]  m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);

    bft_cmd_t           cmd;
    bft_stat_t          stat;
    flow_status_t       out_status;
    logic [SLOT_W-1:0]  out_slot;
    logic [COUNT_W-1:0] out_count;

    // Sequencing of each item.
    bft_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_sweep (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Entry memory, scan pointers and result registers.
    bft_datapath #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_sweep   (s_axis_tuser[0]),
        .in_tuple   (s_axis_tdata[95:0]),
        .in_time    (s_axis_tdata[127:96]),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (out_status),
        .out_slot   (out_slot),
        .out_count  (out_count)
    );

    assign m_axis_tuser = out_status;
    assign m_axis_tdata = {3'b000, out_count, out_slot};

endmodule

// ----- rtl/core/bft_datapath.sv -----
module bft_datapath
    import bft_pkg::*;
#(
    parameter int FLOW_ENTRIES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bft_cmd_t            cmd,
    output bft_stat_t           stat,
    input  logic                in_sweep,
    input  logic [TUPLE_W-1:0]  in_tuple,
    input  logic [TIME_W-1:0]   in_time,
    input  logic                cfg_we,
    input  logic [TMO_W-1:0]    cfg_wdata,
    input  logic                out_ready,
    output logic                out_valid,
    output flow_status_t        out_status,
    output logic [SLOT_W-1:0]   out_slot,
    output logic [COUNT_W-1:0]  out_count
);

    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FLOW_ENTRIES);

    // Entry storage: tuple and last-seen time share addresses.
    logic [TUPLE_W-1:0] tuple_mem [FLOW_ENTRIES];
    logic [TIME_W-1:0]  time_mem  [FLOW_ENTRIES];

    logic [TUPLE_W-1:0] tuple_in_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               item_sweep_reg;
    logic [TMO_W-1:0]   timeout_reg;

    logic [CNT_W-1:0]   live_reg, live_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   keep_reg, keep_next;
    logic               dv_reg, dv_next;
    logic [IDX_W-1:0]   di_reg;
    logic [TUPLE_W-1:0] rd_tuple_reg;
    logic [TIME_W-1:0]  rd_time_reg;

    flow_status_t       res_status_reg;
    logic [IDX_W-1:0]   res_slot_reg;

    logic               out_valid_reg;
    flow_status_t       out_status_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               issue;
    logic               fwd_match;
    logic               rev_match;
    logic               hit;
    logic [TIME_W-1:0]  age;
    logic               alive;
    logic               keep_wr;
    logic               touch;
    logic [TUPLE_W-1:0] rev_tuple;
    logic               tuple_we;
    logic               time_we;
    logic [IDX_W-1:0]   waddr;
    logic [TUPLE_W-1:0] wtuple;
    logic [TIME_W-1:0]  wtime;

    // Compare the entry read last cycle against the item, both directions.
    assign issue     = cmd.rd_go && (rd_ptr_reg < live_reg);
    assign rev_tuple = {tuple_in_reg[79:64], tuple_in_reg[95:80],
                        tuple_in_reg[31:0], tuple_in_reg[63:32]};
    assign fwd_match = (rd_tuple_reg == tuple_in_reg);
    assign rev_match = (rd_tuple_reg == rev_tuple);
    assign hit       = dv_reg && (fwd_match || rev_match);

    // Age is a modular difference; an entry survives while it is younger
    // than the timeout.
    assign age     = now_reg - rd_time_reg;
    assign alive   = age < {{(TIME_W-TMO_W){1'b0}}, timeout_reg};
    assign keep_wr = cmd.sweep_en && dv_reg && alive;
    assign touch   = cmd.scan_en && hit;

    // Single write port shared by compaction, refresh and append.
    always_comb begin
        tuple_we = keep_wr || cmd.append_wr;
        time_we  = keep_wr || touch || cmd.append_wr;
        if (keep_wr) begin
            waddr  = keep_reg[IDX_W-1:0];
            wtuple = rd_tuple_reg;
            wtime  = rd_time_reg;
        end else if (touch) begin
            waddr  = di_reg;
            wtuple = tuple_in_reg;
            wtime  = now_reg;
        end else begin
            waddr  = live_reg[IDX_W-1:0];
            wtuple = tuple_in_reg;
            wtime  = now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tuple_we) begin
            tuple_mem[waddr] <= wtuple;
        end
        if (issue) begin
            rd_tuple_reg <= tuple_mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (time_we) begin
            time_mem[waddr] <= wtime;
        end
        if (issue) begin
            rd_time_reg <= time_mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    // Scan pointers and the live count.
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        keep_next   = keep_reg;
        dv_next     = issue;
        live_next   = live_reg;
        if (cmd.ptr_clear) begin
            rd_ptr_next = '0;
            keep_next   = '0;
            dv_next     = 1'b0;
        end else begin
            if (issue) begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
            if (keep_wr) begin
                keep_next = keep_reg + 1'b1;
            end
        end
        if (cmd.sweep_commit) begin
            live_next = keep_reg;
        end else if (cmd.append_wr) begin
            live_next = live_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            rd_ptr_reg  <= '0;
            keep_reg    <= '0;
            dv_reg      <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            live_reg   <= live_next;
            rd_ptr_reg <= rd_ptr_next;
            keep_reg   <= keep_next;
            dv_reg     <= dv_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // Item capture, read tag and the pending result.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            tuple_in_reg   <= in_tuple;
            now_reg        <= in_time;
            item_sweep_reg <= in_sweep;
        end
        if (issue) begin
            di_reg <= rd_ptr_reg[IDX_W-1:0];
        end
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_status)
                FLOW_FOUND: res_slot_reg <= di_reg;
                FLOW_NEW:   res_slot_reg <= live_reg[IDX_W-1:0];
                default:    res_slot_reg <= '0;
            endcase
        end
    end

    // Output register; the count is sampled after the item's updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= SLOT_W'(res_slot_reg);
            out_count_reg  <= COUNT_W'(live_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_count  = out_count_reg;

    assign stat.item_sweep = item_sweep_reg;
    assign stat.hit        = hit;
    assign stat.scan_done  = !dv_reg && (rd_ptr_reg >= live_reg);
    assign stat.table_full = (live_reg == FULL_COUNT);
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

// ----- rtl/core/bft_ctrl.sv -----
module bft_ctrl
    import bft_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      in_sweep,
    output logic      in_ready,
    input  bft_stat_t stat,
    output bft_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_SWEEP  = 5'b00100,
        S_APPEND = 5'b01000,
        S_REPORT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Per item: scan (lookups), optional sweep and append, report.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = FLOW_FOUND;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture   = 1'b1;
                    cmd.ptr_clear = 1'b1;
                    state_next    = in_sweep ? S_SWEEP : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                cmd.rd_go   = 1'b1;
                if (stat.hit) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = FLOW_FOUND;
                    state_next     = S_REPORT;
                end else if (stat.scan_done) begin
                    if (stat.table_full) begin
                        cmd.ptr_clear = 1'b1;
                        state_next    = S_SWEEP;
                    end else begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_SWEEP: begin
                cmd.sweep_en = 1'b1;
                cmd.rd_go    = 1'b1;
                if (stat.scan_done) begin
                    cmd.sweep_commit = 1'b1;
                    if (stat.item_sweep) begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = FLOW_SWEEP;
                        state_next     = S_REPORT;
                    end else begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND: begin
                cmd.res_set = 1'b1;
                if (stat.table_full) begin
                    cmd.res_status = FLOW_FULL;
                end else begin
                    cmd.append_wr  = 1'b1;
                    cmd.res_status = FLOW_NEW;
                end
                state_next = S_REPORT;
            end
            S_REPORT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
